### src/psa_pkg.sv
`timescale 1ns / 1ps

package psa_pkg;

  // Fixed widths of the datapath.
  localparam int WORD_W = 16;  // occupancy bits per memory word
  localparam int BIT_W  = 4;   // bit position within a word
  localparam int SLOT_W = 12;  // slot number within a page
  localparam int COL_W  = 7;   // slots per row
  localparam int SPP_W  = 13;  // slots per page
  localparam int CNT_W  = 13;  // used count of one page
  localparam int CFG_W  = 14;  // configuration data
  localparam int DVD_W  = 14;  // divider dividend and quotient
  localparam int DVS_W  = 15;  // divider divisor and remainder

  // Configuration register indexes.
  localparam logic [1:0] REG_ATLAS  = 2'd0;
  localparam logic [1:0] REG_SLOT   = 2'd1;
  localparam logic [1:0] REG_GUTTER = 2'd2;

  // Operation codes.
  localparam logic [2:0] KIND_ALLOC   = 3'd0;
  localparam logic [2:0] KIND_FREE    = 3'd1;
  localparam logic [2:0] KIND_RESOLVE = 3'd2;
  localparam logic [2:0] KIND_TRIM    = 3'd3;
  localparam logic [2:0] KIND_QUERY   = 3'd4;

  typedef enum logic [2:0] {
    RES_FAIL,
    RES_PLAIN,
    RES_EMIT,
    RES_TRIM,
    RES_QUERY
  } res_kind_t;

  typedef struct packed {
    logic      accept;
    logic      geo_start;
    logic      geo_load;
    logic      spp_load;
    logic      scan_init;
    logic      page_next;
    logic      word_rd;
    logic      word_next;
    logic      take_slot;
    logic      bit_rd;
    logic      free_commit;
    logic      new_init;
    logic      clr_step;
    logic      new_commit;
    logic      div_start;
    logic      mul_load;
    logic      trim_step;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic       geo_valid;
    logic [2:0] kind;
    logic       pre_fail;
    logic       scan_end;
    logic       page_full;
    logic       pool_full;
    logic       found;
    logic       last_word;
    logic       bit_set;
    logic       clr_last;
    logic       trim_more;
    logic       div_done;
    logic       out_free;
  } sts_t;

  // Lowest set bit of a word.
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### src/psa_div.sv
`timescale 1ns / 1ps

module psa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [psa_pkg::DVD_W-1:0] dividend,
  input  logic [psa_pkg::DVS_W-1:0] divisor,
  output logic [psa_pkg::DVD_W-1:0] quot,
  output logic [psa_pkg::DVS_W-1:0] rem,
  output logic                      done
);
  import psa_pkg::*;

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [3:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   tmp;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One restoring step per cycle, one quotient bit per step.
  always_comb begin
    tmp  = {rem_r, dvd_r[DVD_W-1]};
    ge   = tmp >= {1'b0, dvs_r};
    diff = tmp - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      cnt_r  <= 4'(DVD_W - 1);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : tmp[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      if (cnt_r == 4'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 4'd1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign quot = dvd_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

### src/psa_ctrl.sv
`timescale 1ns / 1ps

module psa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  psa_pkg::sts_t sts,
  output psa_pkg::cmd_t cmd
);
  import psa_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_GEO  = 14'b00000000000010,
    S_GFIN = 14'b00000000000100,
    S_DEC  = 14'b00000000001000,
    S_SCAN = 14'b00000000010000,
    S_SRD  = 14'b00000000100000,
    S_SCHK = 14'b00000001000000,
    S_CLR  = 14'b00000010000000,
    S_BCHK = 14'b00000100000000,
    S_DST  = 14'b00001000000000,
    S_DIV  = 14'b00010000000000,
    S_MUL  = 14'b00100000000000,
    S_TRIM = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_t;

  state_t    state_r, state_nxt;
  res_kind_t rk_r, rk_nxt;

  always_comb begin
    state_nxt    = state_r;
    rk_nxt       = rk_r;
    cmd          = '0;
    cmd.res_kind = rk_r;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!sts.geo_valid) begin
          cmd.geo_start = 1'b1;
          state_nxt     = S_GEO;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_nxt  = S_DEC;
          end
        end
      end
      S_GEO: begin
        if (sts.div_done) begin
          cmd.geo_load = 1'b1;
          state_nxt    = S_GFIN;
        end
      end
      S_GFIN: begin
        cmd.spp_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DEC: begin
        case (sts.kind)
          KIND_ALLOC: begin
            if (sts.pre_fail) begin
              rk_nxt    = RES_FAIL;
              state_nxt = S_FIN;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          KIND_FREE, KIND_RESOLVE: begin
            if (sts.pre_fail) begin
              rk_nxt    = RES_FAIL;
              state_nxt = S_FIN;
            end else begin
              cmd.bit_rd = 1'b1;
              state_nxt  = S_BCHK;
            end
          end
          KIND_TRIM: begin
            state_nxt = S_TRIM;
          end
          KIND_QUERY: begin
            rk_nxt    = RES_QUERY;
            state_nxt = S_FIN;
          end
          default: begin
            rk_nxt    = RES_FAIL;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          if (sts.pool_full) begin
            rk_nxt    = RES_FAIL;
            state_nxt = S_FIN;
          end else begin
            cmd.new_init = 1'b1;
            state_nxt    = S_CLR;
          end
        end else if (sts.page_full) begin
          cmd.page_next = 1'b1;
        end else begin
          cmd.word_rd = 1'b1;
          state_nxt   = S_SCHK;
        end
      end
      S_SRD: begin
        cmd.word_rd = 1'b1;
        state_nxt   = S_SCHK;
      end
      S_SCHK: begin
        if (sts.found) begin
          cmd.take_slot = 1'b1;
          state_nxt     = S_DST;
        end else if (sts.last_word) begin
          cmd.page_next = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.word_next = 1'b1;
          state_nxt     = S_SRD;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.new_commit = 1'b1;
          state_nxt      = S_DST;
        end
      end
      S_BCHK: begin
        if (!sts.bit_set) begin
          rk_nxt    = RES_FAIL;
          state_nxt = S_FIN;
        end else if (sts.kind == KIND_FREE) begin
          cmd.free_commit = 1'b1;
          rk_nxt          = RES_PLAIN;
          state_nxt       = S_FIN;
        end else begin
          state_nxt = S_DST;
        end
      end
      S_DST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        rk_nxt       = RES_EMIT;
        state_nxt    = S_FIN;
      end
      S_TRIM: begin
        if (sts.trim_more) begin
          cmd.trim_step = 1'b1;
        end else begin
          rk_nxt    = RES_TRIM;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rk_r    <= RES_FAIL;
    end else begin
      state_r <= state_nxt;
      rk_r    <= rk_nxt;
    end
  end

endmodule

### src/psa_dp.sv
`timescale 1ns / 1ps

module psa_dp #(
  parameter int MAX_PAGES = 16,
  parameter int MAX_COLS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [psa_pkg::CFG_W-1:0] cfg_data,
  input  logic [2:0]                in_kind,
  input  logic [3:0]                in_page_index,
  input  logic [7:0]                in_slot_index,
  input  logic [13:0]               in_width,
  input  logic [13:0]               in_height,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_ok,
  output logic [3:0]                out_out_page,
  output logic [7:0]                out_out_slot,
  output logic [12:0]               out_slot_x,
  output logic [12:0]               out_slot_y,
  output logic [12:0]               out_content_x,
  output logic [12:0]               out_content_y,
  output logic [13:0]               out_out_width,
  output logic [13:0]               out_out_height,
  output logic [4:0]                out_pages_removed,
  output logic [8:0]                out_page_used,
  input  psa_pkg::cmd_t             cmd,
  output psa_pkg::sts_t             sts
);
  import psa_pkg::*;

  localparam int SLOTS_CAP = MAX_COLS * MAX_COLS;
  localparam int WPP       = (SLOTS_CAP + WORD_W - 1) / WORD_W;
  localparam int DEPTH     = MAX_PAGES * WPP;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW        = (WPP > 1) ? $clog2(WPP) : 1;
  localparam int PW        = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PCW       = $clog2(MAX_PAGES + 1);

  // Configuration and derived geometry.
  logic [CFG_W-1:0] atlas_r, slotsz_r;
  logic [7:0]       gutter_r;
  logic [COL_W-1:0] cols_r;
  logic [SPP_W-1:0] spp_r;
  logic             geo_valid_r, stale_r;
  logic [DVS_W-1:0] fp;
  logic             geo_chk;

  // Captured beat.
  logic [2:0]  kind_r;
  logic [3:0]  page_r;
  logic [7:0]  slot_in_r;
  logic [13:0] w_r, h_r;

  // Allocation state.
  logic [CNT_W-1:0] cnt_r [MAX_PAGES];
  logic [PCW-1:0]   page_count_r;
  logic [12:0]      total_r;
  logic [PCW-1:0]   ptr_r;
  logic [WW-1:0]    wrd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [PCW-1:0]   pg_r;
  logic [4:0]       removed_r;
  logic [12:0]      sx_r, sy_r;

  // Occupancy memory.
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] wdata;
  logic [AW-1:0]     mem_addr;
  logic              mem_we, mem_re;

  // Divider hookup.
  logic [DVD_W-1:0] div_dvd, div_quot;
  logic [DVS_W-1:0] div_dvs, div_rem;
  logic             div_done;

  logic [PW-1:0]     ptr_idx, page_idx, top_idx;
  logic [PCW-1:0]    pc_m1;
  logic [31:0]       page_ext, addr_full, slot_scan, pg_ext;
  logic [WORD_W-1:0] vmask, free_m;
  logic [BIT_W-1:0]  bitpos;
  logic              size_ok, page_ok, slot_ok, geo_ok;
  logic [29:0]       sx_p, sy_p;
  logic [DVD_W-1:0]  cols_cap;

  assign fp      = DVS_W'(slotsz_r) + DVS_W'({gutter_r, 1'b0});
  assign geo_chk = (atlas_r != '0) && (slotsz_r != '0) && ({1'b0, atlas_r} >= fp);
  assign geo_ok  = cols_r != '0;

  assign page_ext = {28'd0, page_r};
  assign page_idx = page_ext[PW-1:0];
  assign ptr_idx  = ptr_r[PW-1:0];
  assign pc_m1    = page_count_r - PCW'(1);
  assign top_idx  = pc_m1[PW-1:0];

  assign size_ok = (w_r != '0) && (h_r != '0) && (w_r <= slotsz_r) && (h_r <= slotsz_r);
  assign page_ok = 32'(page_r) < 32'(page_count_r);
  assign slot_ok = 32'(slot_in_r) < 32'(spp_r);

  // Memory address: page base plus word within the page.
  always_comb begin
    int pg_i;
    int wd_i;
    if (cmd.clr_step) begin
      pg_i = int'(page_count_r);
      wd_i = int'(wrd_r);
    end else if (cmd.bit_rd || cmd.free_commit) begin
      pg_i = int'(page_r);
      wd_i = int'(slot_in_r[7:4]);
    end else begin
      pg_i = int'(ptr_r);
      wd_i = int'(wrd_r);
    end
    addr_full = 32'(pg_i * WPP + wd_i);
  end
  assign mem_addr = addr_full[AW-1:0];

  // Slots of the current word that lie inside the page.
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      vmask[i] = (int'(wrd_r) * WORD_W + i) < int'(spp_r);
    end
    free_m = ~rd_data_r & vmask;
    bitpos = first_set(free_m);
  end
  assign slot_scan = 32'(int'(wrd_r) * WORD_W + int'(bitpos));

  always_comb begin
    if (cmd.clr_step) begin
      wdata = (wrd_r == '0) ? WORD_W'(1) : '0;
    end else if (cmd.take_slot) begin
      wdata = rd_data_r | (WORD_W'(1) << bitpos);
    end else begin
      wdata = rd_data_r & ~(WORD_W'(1) << slot_in_r[3:0]);
    end
  end
  assign mem_we = cmd.clr_step | cmd.take_slot | cmd.free_commit;
  assign mem_re = cmd.word_rd | cmd.bit_rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  assign div_dvd = cmd.geo_start ? atlas_r : DVD_W'(slot_r);
  assign div_dvs = cmd.geo_start ? fp : DVS_W'(cols_r);

  psa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.geo_start | cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  assign cols_cap = (div_quot > DVD_W'(MAX_COLS)) ? DVD_W'(MAX_COLS) : div_quot;
  assign sx_p     = {15'd0, div_rem} * {15'd0, fp};
  assign sy_p     = {16'd0, div_quot} * {15'd0, fp};

  // Configuration and geometry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_r     <= CFG_W'(4096);
      slotsz_r    <= CFG_W'(256);
      gutter_r    <= 8'd2;
      geo_valid_r <= 1'b0;
      stale_r     <= 1'b0;
      cols_r      <= '0;
      spp_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ATLAS:  atlas_r  <= cfg_data;
          REG_SLOT:   slotsz_r <= cfg_data;
          REG_GUTTER: gutter_r <= cfg_data[7:0];
          default:    ;
        endcase
      end
      if (cfg_wr_en) begin
        stale_r <= 1'b1;
      end else if (cmd.geo_start) begin
        stale_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        geo_valid_r <= 1'b0;
      end else if (cmd.spp_load) begin
        geo_valid_r <= !stale_r;
      end
      if (cmd.geo_load) begin
        cols_r <= geo_chk ? cols_cap[COL_W-1:0] : '0;
      end
      if (cmd.spp_load) begin
        spp_r <= {6'd0, cols_r} * {6'd0, cols_r};
      end
    end
  end

  // Page bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PAGES; i++) begin
        cnt_r[i] <= '0;
      end
      page_count_r <= '0;
      total_r      <= '0;
    end else begin
      if (cmd.take_slot) begin
        cnt_r[ptr_idx] <= cnt_r[ptr_idx] + CNT_W'(1);
      end
      if (cmd.new_commit) begin
        cnt_r[page_count_r[PW-1:0]] <= CNT_W'(1);
        page_count_r                <= page_count_r + PCW'(1);
      end
      if (cmd.free_commit && (cnt_r[page_idx] != '0)) begin
        cnt_r[page_idx] <= cnt_r[page_idx] - CNT_W'(1);
      end
      if (cmd.trim_step) begin
        page_count_r <= pc_m1;
      end
      if ((cmd.take_slot || cmd.new_commit) && (total_r != 13'h1FFF)) begin
        total_r <= total_r + 13'd1;
      end else if (cmd.free_commit && (total_r != '0)) begin
        total_r <= total_r - 13'd1;
      end
    end
  end

  // Per-operation working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= in_kind;
      page_r    <= in_page_index;
      slot_in_r <= in_slot_index;
      w_r       <= in_width;
      h_r       <= in_height;
      slot_r    <= SLOT_W'(in_slot_index);
      pg_r      <= PCW'(in_page_index);
      removed_r <= '0;
    end
    if (cmd.scan_init) begin
      ptr_r <= '0;
    end else if (cmd.page_next) begin
      ptr_r <= ptr_r + PCW'(1);
    end
    if (cmd.scan_init || cmd.page_next || cmd.new_init) begin
      wrd_r <= '0;
    end else if (cmd.word_next || cmd.clr_step) begin
      wrd_r <= wrd_r + WW'(1);
    end
    if (cmd.take_slot) begin
      slot_r <= slot_scan[SLOT_W-1:0];
      pg_r   <= ptr_r;
    end
    if (cmd.new_commit) begin
      slot_r <= '0;
      pg_r   <= page_count_r;
    end
    if (cmd.trim_step) begin
      removed_r <= removed_r + 5'd1;
    end
    if (cmd.mul_load) begin
      sx_r <= sx_p[12:0];
      sy_r <= sy_p[12:0];
    end
  end

  assign pg_ext = 32'(pg_r);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_ok            <= 1'b0;
      out_out_page      <= '0;
      out_out_slot      <= '0;
      out_slot_x        <= '0;
      out_slot_y        <= '0;
      out_content_x     <= '0;
      out_content_y     <= '0;
      out_out_width     <= '0;
      out_out_height    <= '0;
      out_pages_removed <= '0;
      out_page_used     <= '0;
      case (cmd.res_kind)
        RES_PLAIN: begin
          out_ok <= 1'b1;
        end
        RES_EMIT: begin
          out_ok         <= 1'b1;
          out_out_page   <= pg_ext[3:0];
          out_out_slot   <= slot_r[7:0];
          out_slot_x     <= sx_r;
          out_slot_y     <= sy_r;
          out_content_x  <= sx_r + {5'd0, gutter_r};
          out_content_y  <= sy_r + {5'd0, gutter_r};
          out_out_width  <= w_r;
          out_out_height <= h_r;
        end
        RES_TRIM: begin
          out_ok            <= 1'b1;
          out_pages_removed <= removed_r;
        end
        RES_QUERY: begin
          out_ok <= 1'b1;
          if (page_ok) begin
            out_page_used <= cnt_r[page_idx][8:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    sts           = '0;
    sts.geo_valid = geo_valid_r;
    sts.kind      = kind_r;
    if (kind_r == KIND_ALLOC) begin
      sts.pre_fail = !geo_ok || !size_ok;
    end else begin
      sts.pre_fail = !geo_ok || ((kind_r == KIND_RESOLVE) && !size_ok) || !page_ok || !slot_ok;
    end
    sts.scan_end  = ptr_r >= page_count_r;
    sts.page_full = SPP_W'(cnt_r[ptr_idx]) >= spp_r;
    sts.pool_full = 32'(page_count_r) >= 32'(MAX_PAGES);
    sts.found     = free_m != '0;
    sts.last_word = (int'(wrd_r) * WORD_W + WORD_W) >= int'(spp_r);
    sts.bit_set   = rd_data_r[slot_in_r[3:0]];
    sts.clr_last  = wrd_r == WW'(WPP - 1);
    sts.trim_more = (page_count_r != '0) && (cnt_r[top_idx] == '0);
    sts.div_done  = div_done;
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

### src/paged_slot_allocator_unit.sv
`timescale 1ns / 1ps
// A query or a beat rejected at decode goes straight to the result register; a free, or a free or
// resolve that finds its slot empty, is settled by one bitmap read; a trim removes empty pages from the
// top one by one; resolve and allocate divide for the slot coordinates, and allocate first scans the
// bitmap, skipping full pages, and opens and clears a new page if none has room. One beat at a time.
// Reset: synchronous active-low rst_n clears all pages and counts and restores register defaults;
// the slot geometry is then recomputed, and again after every configuration write.
module paged_slot_allocator_unit #(
  parameter int MAX_PAGES = 16,
  parameter int MAX_COLS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration write port.
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [psa_pkg::CFG_W-1:0] cfg_data,
  // Request channel.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_kind,
  input  logic [3:0]                in_page_index,
  input  logic [7:0]                in_slot_index,
  input  logic [13:0]               in_width,
  input  logic [13:0]               in_height,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_ok,
  output logic [3:0]                out_out_page,
  output logic [7:0]                out_out_slot,
  output logic [12:0]               out_slot_x,
  output logic [12:0]               out_slot_y,
  output logic [12:0]               out_content_x,
  output logic [12:0]               out_content_y,
  output logic [13:0]               out_out_width,
  output logic [13:0]               out_out_height,
  output logic [4:0]                out_pages_removed,
  output logic [8:0]                out_page_used
);
  import psa_pkg::*;

  // The controller sequences each beat through decode, bitmap scan or lookup, the shared
  // divider for slot coordinates, and the result register. The datapath holds the bitmap
  // memory (16 slots per word), the per-page used counts and the geometry registers.
  cmd_t cmd;
  sts_t sts;

  psa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psa_dp #(
    .MAX_PAGES (MAX_PAGES),
    .MAX_COLS  (MAX_COLS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_kind           (in_kind),
    .in_page_index     (in_page_index),
    .in_slot_index     (in_slot_index),
    .in_width          (in_width),
    .in_height         (in_height),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_out_page      (out_out_page),
    .out_out_slot      (out_out_slot),
    .out_slot_x        (out_slot_x),
    .out_slot_y        (out_slot_y),
    .out_content_x     (out_content_x),
    .out_content_y     (out_content_y),
    .out_out_width     (out_out_width),
    .out_out_height    (out_out_height),
    .out_pages_removed (out_pages_removed),
    .out_page_used     (out_page_used),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
